@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
package spq_pkg;

	localparam int VAL_W = 32;
	localparam int OCC_W = 7;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} spq_status_t;

	typedef struct packed {
		spq_cmd_t                  cmd;
		logic signed [VAL_W-1:0]   value;
	} spq_req_t;

	typedef struct packed {
		spq_status_t               status;
		logic signed [VAL_W-1:0]   popped_value;
		logic signed [VAL_W-1:0]   head_value;
		logic                      is_empty;
		logic [OCC_W-1:0]          occupancy;
	} spq_rsp_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic ins;   // accepted enqueue that fits
		logic del;   // accepted dequeue on a non-empty queue
	} spq_ctl_t;

endpackage

@@ sv/spq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted chain: holds one value, compares it to the broadcast
// value and takes it or an upper or lower neighbor's. Depends on spq_pkg.
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::spq_ctl_t                 ctl,
	input  logic                              occupied,
	input  logic signed [spq_pkg::VAL_W-1:0]  new_val,
	input  logic                              up_go,
	input  logic signed [spq_pkg::VAL_W-1:0]  up_val,
	input  logic signed [spq_pkg::VAL_W-1:0]  down_val,
	output logic                              go,
	output logic signed [spq_pkg::VAL_W-1:0]  val
);
	import spq_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	// slot is free or holds a strictly lower value: insertion lands here or above
	assign go  = !occupied || (val_q < new_val);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.del) begin
			val_q <= down_val;
		end else if (ctl.ins && go) begin
			if (up_go) begin
				val_q <= up_val;
			end else begin
				val_q <= new_val;
			end
		end
	end

endmodule

@@ sv/sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// Sorted priority queue built as a chain of DEPTH spq_cell slots, head at slot 0.
// Depends on spq_pkg and spq_cell.
//
//  channel | valid     | stall     | payload            | dir
//  --------+-----------+-----------+--------------------+-----
//  request | req_valid | req_stall | req (spq_req_t)    | in
//  result  | rsp_valid | rsp_stall | rsp (spq_rsp_t)    | out
//
// All cells compare against the broadcast value and shift in parallel, so one
// request is taken each clock while req_stall is low.
// The result is registered and appears the cycle after acceptance.
// req_stall is raised only while a held result is stalled at the output.
// Reset clears the count and the output valid; slot contents are not cleared.
module sorted_priority_queue_core #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spq_pkg::spq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W+OCC_W-1:0] DEPTH_EXT = (CNT_W + OCC_W)'(DEPTH);

	logic [CNT_W-1:0]        cnt_q;
	logic                    rsp_valid_q;
	spq_rsp_t                rsp_q;

	logic                    fire;
	logic                    full;
	logic                    empty;
	spq_ctl_t                ctl;
	logic [CNT_W-1:0]        cnt_nxt;
	logic [CNT_W+OCC_W-1:0]  cnt_ext;
	spq_rsp_t                rsp_nxt;

	logic                    go   [DEPTH];
	logic signed [VAL_W-1:0] vals [DEPTH];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);

	assign ctl.ins = fire && (req.cmd == CMD_ENQ) && !full;
	assign ctl.del = fire && (req.cmd == CMD_DEQ) && !empty;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                    up_go;
			logic signed [VAL_W-1:0] up_val;
			logic signed [VAL_W-1:0] down_val;

			if (gi == 0) begin : g_top
				assign up_go  = 1'b0;
				assign up_val = '0;
			end else begin : g_mid
				assign up_go  = go[gi-1];
				assign up_val = vals[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_bot
				assign down_val = '0;
			end else begin : g_low
				assign down_val = vals[gi+1];
			end

			spq_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occupied (CNT_W'(gi) < cnt_q),
				.new_val  (req.value),
				.up_go    (up_go),
				.up_val   (up_val),
				.down_val (down_val),
				.go       (go[gi]),
				.val      (vals[gi])
			);
		end
	endgenerate

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctl.ins) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (ctl.del) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	assign cnt_ext = {{OCC_W{1'b0}}, cnt_nxt};

	always_comb begin
		rsp_nxt              = '0;
		rsp_nxt.status       = ST_OK;
		rsp_nxt.is_empty     = (cnt_nxt == '0);
		rsp_nxt.occupancy    = cnt_ext[OCC_W-1:0];
		rsp_nxt.head_value   = empty ? '0 : vals[0];
		rsp_nxt.popped_value = '0;
		case (req.cmd)
			CMD_ENQ: begin
				if (full) begin
					rsp_nxt.status = ST_OVERFLOW;
				end else if (go[0]) begin
					// new value becomes the head (also covers an empty queue)
					rsp_nxt.head_value = req.value;
				end
			end
			CMD_DEQ: begin
				if (empty) begin
					rsp_nxt.status = ST_UNDERFLOW;
				end else begin
					rsp_nxt.popped_value = vals[0];
					rsp_nxt.head_value   = (cnt_q > CNT_W'(1)) ? vals[1] : '0;
				end
			end
			default: begin
				rsp_nxt.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_OVERFLOW) |->
			(rsp.occupancy == DEPTH_EXT[OCC_W-1:0]) && (rsp.popped_value == '0))
		else $error("overflow reported while queue not full");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> (rsp.head_value == '0))
		else $error("empty queue reports a nonzero head");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.cmd == CMD_DEQ) && !empty |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("dequeue did not lower the count by one");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.cmd == CMD_DEQ) && empty |=>
			rsp_valid && (rsp.status == ST_UNDERFLOW) && rsp.is_empty)
		else $error("dequeue on empty queue not reported as underflow");

endmodule
